>>> design/assert_macros.svh
// assertion macros shared by the decoder rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/utf8sd_pkg.sv
// types and constants for the utf-8 stream decoder
// no dependencies; used by every module of the decoder
package utf8sd_pkg;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD   = 2'd1;
  localparam logic [1:0] ST_BROKEN     = 2'd2;
  localparam logic [1:0] ST_DISALLOWED = 2'd3;

  localparam int ACC_W  = 31;
  localparam int CP_W   = 21;
  localparam int PEND_W = 3;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [1:0]      status;
    logic            run_last;
  } out_item_t;

  // up to two results produced by one word
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

>>> design/utf8sd_decode.sv
// per-word decode logic: next accumulator, pending count and results
// depends on utf8sd_pkg
module utf8sd_decode (
  input  utf8sd_pkg::in_item_t            item,
  input  logic [utf8sd_pkg::ACC_W-1:0]    acc,
  input  logic [utf8sd_pkg::PEND_W-1:0]   pend,
  output logic [utf8sd_pkg::ACC_W-1:0]    acc_nxt,
  output logic [utf8sd_pkg::PEND_W-1:0]   pend_nxt,
  output utf8sd_pkg::push_t               res
);

  logic [7:0]                      b;
  logic [utf8sd_pkg::ACC_W-1:0]    acc_shift;
  logic [utf8sd_pkg::PEND_W-1:0]   pend_dec;
  logic                            lead_emit;
  logic [1:0]                      lead_st;
  logic [utf8sd_pkg::CP_W-1:0]     lead_cp;
  logic                            lead_open;
  logic [utf8sd_pkg::PEND_W-1:0]   lead_pend;
  logic [utf8sd_pkg::ACC_W-1:0]    lead_acc;
  logic                            bad_val;
  logic [2:0]                      cand_v;
  utf8sd_pkg::out_item_t           cand [3];
  logic [1:0]                      n;

  assign b         = item.data_byte;
  assign acc_shift = {acc[utf8sd_pkg::ACC_W-7:0], b[5:0]};
  assign pend_dec  = pend - 3'd1;

  always_comb begin
    lead_emit = 1'b0;
    lead_st   = utf8sd_pkg::ST_OK;
    lead_cp   = '0;
    lead_open = 1'b0;
    lead_pend = '0;
    lead_acc  = '0;
    if (b < 8'h80) begin
      lead_emit = 1'b1;
      lead_cp   = {13'd0, b};
    end else if (b < 8'hC0) begin
      lead_emit = 1'b1;
      lead_st   = utf8sd_pkg::ST_BAD_LEAD;
    end else if (b < 8'hE0) begin
      lead_open = 1'b1;
      lead_pend = 3'd1;
      lead_acc  = {26'd0, b[4:0]};
    end else if (b < 8'hF0) begin
      lead_open = 1'b1;
      lead_pend = 3'd2;
      lead_acc  = {27'd0, b[3:0]};
    end else if (b < 8'hF8) begin
      lead_open = 1'b1;
      lead_pend = 3'd3;
      lead_acc  = {28'd0, b[2:0]};
    end else if (b < 8'hFC) begin
      lead_open = 1'b1;
      lead_pend = 3'd4;
      lead_acc  = {29'd0, b[1:0]};
    end else if (b < 8'hFE) begin
      lead_open = 1'b1;
      lead_pend = 3'd5;
      lead_acc  = {30'd0, b[0]};
    end else begin
      lead_emit = 1'b1;
      lead_st   = utf8sd_pkg::ST_BAD_LEAD;
    end
  end

  // surrogates, the two noncharacters and anything past the unicode range
  assign bad_val = (acc_shift >= 31'h0000_D800 && acc_shift <= 31'h0000_DFFF) ||
                   acc_shift == 31'h0000_FFFE || acc_shift == 31'h0000_FFFF ||
                   acc_shift > 31'h0010_FFFF;

  always_comb begin
    cand_v  = '0;
    cand[0] = '0;
    cand[1] = '0;
    cand[2] = '0;
    acc_nxt  = acc;
    pend_nxt = pend;
    if (pend != '0 && b[7:6] == 2'b10) begin
      if (pend_dec == '0) begin
        cand_v[0] = 1'b1;
        cand[0].status     = bad_val ? utf8sd_pkg::ST_DISALLOWED : utf8sd_pkg::ST_OK;
        cand[0].code_point = bad_val ? '0 : acc_shift[utf8sd_pkg::CP_W-1:0];
        acc_nxt  = '0;
        pend_nxt = '0;
      end else begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_dec;
      end
    end else begin
      if (pend != '0) begin
        // open sequence broken by a non-continuation word
        cand_v[0]      = 1'b1;
        cand[0].status = utf8sd_pkg::ST_BROKEN;
      end
      cand_v[1]          = lead_emit;
      cand[1].status     = lead_st;
      cand[1].code_point = lead_cp;
      acc_nxt  = lead_open ? lead_acc : '0;
      pend_nxt = lead_open ? lead_pend : '0;
    end
    // string ends inside a sequence
    if (item.is_last && pend_nxt != '0) begin
      cand_v[2]      = 1'b1;
      cand[2].status = utf8sd_pkg::ST_BROKEN;
      acc_nxt  = '0;
      pend_nxt = '0;
    end
  end

  always_comb begin
    n         = '0;
    res.cnt   = '0;
    res.item0 = '0;
    res.item1 = '0;
    for (int k = 0; k < 3; k++) begin
      if (cand_v[k]) begin
        if (n == 2'd0) begin
          res.item0 = cand[k];
        end else begin
          res.item1 = cand[k];
        end
        n = n + 2'd1;
      end
    end
    res.cnt = n;
    if (n == 2'd1) begin
      res.item0.run_last = 1'b1;
    end else if (n == 2'd2) begin
      res.item1.run_last = 1'b1;
    end
  end

endmodule

>>> design/utf8sd_rqueue.sv
// result queue: takes up to two results per cycle, hands out one per cycle while out_stall is low
// depends on utf8sd_pkg and assert_macros.svh
`include "assert_macros.svh"

module utf8sd_rqueue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  utf8sd_pkg::push_t      push,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output utf8sd_pkg::out_item_t  out_data
);

  utf8sd_pkg::out_item_t             mem_r [utf8sd_pkg::QDEPTH];
  logic [utf8sd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [utf8sd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [utf8sd_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic [utf8sd_pkg::QPTR_W-1:0]     wr_ptr_p1;
  logic                              pop;

  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // two free slots needed before the next word may be decoded
  assign room      = cnt_r <= 3'(utf8sd_pkg::QDEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push.cnt} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.item1;
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_r <= 3'(utf8sd_pkg::QDEPTH), "result queue overflow")
  `ASSERT_CLK(a_push_room, !(push.cnt != 2'd0 && cnt_r > 3'(utf8sd_pkg::QDEPTH - 2)),
    "push without two free slots")

endmodule

>>> design/utf8_stream_decoder_top.sv
// utf-8 stream decoder: word register, decode logic, result queue
// a word waits in the word register until the queue has room, then is decoded into the result queue
// throughput: one word per cycle while results drain one per cycle and the queue has room;
//   a word that gives two results adds more to the queue than one pop takes out
// reset: rst_n synchronous active low, closes any open sequence and empties the queue
`include "assert_macros.svh"

module utf8_stream_decoder_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  utf8sd_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output utf8sd_pkg::out_item_t  out_data
);

  utf8sd_pkg::in_item_t              in_data_r;
  logic                              in_valid_r, in_valid_nxt;
  logic [utf8sd_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic [utf8sd_pkg::PEND_W-1:0]     pend_r, pend_nxt;
  logic [utf8sd_pkg::ACC_W-1:0]      dec_acc;
  logic [utf8sd_pkg::PEND_W-1:0]     dec_pend;
  utf8sd_pkg::push_t                 dec_res;
  utf8sd_pkg::push_t                 push;
  logic                              room;
  logic                              drain;
  logic                              accept;

  assign drain    = in_valid_r && room;
  assign in_stall = in_valid_r && !room;
  assign accept   = in_valid && !in_stall;

  utf8sd_decode u_dec (
    .item     (in_data_r),
    .acc      (acc_r),
    .pend     (pend_r),
    .acc_nxt  (dec_acc),
    .pend_nxt (dec_pend),
    .res      (dec_res)
  );

  always_comb begin
    push         = dec_res;
    push.cnt     = drain ? dec_res.cnt : 2'd0;
    acc_nxt      = drain ? dec_acc : acc_r;
    pend_nxt     = drain ? dec_pend : pend_r;
    in_valid_nxt = accept ? 1'b1 : (drain ? 1'b0 : in_valid_r);
  end

  utf8sd_rqueue u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      acc_r      <= '0;
      pend_r     <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      acc_r      <= acc_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
  end

  `ASSERT_CLK(a_pend_range, pend_r <= 3'd5, "pending count out of range")
  `ASSERT_CLK(a_acc_closed, !(pend_r == '0 && acc_r != '0), "accumulator dirty with no sequence")
  `ASSERT_NEXT(a_last_closes, drain && in_data_r.is_last, pend_r == '0,
    "sequence left open after last word")
  `ASSERT_NEXT(a_word_held, in_valid_r && !drain, in_valid_r && $stable(in_data_r),
    "word lost while waiting for queue room")

endmodule

>>> verif/utf8sd_checker.sv
// result checker for the utf-8 stream decoder: predicts code points from accepted words
// and compares them with the result channel; depends on utf8sd_pkg only
module utf8sd_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  utf8sd_pkg::in_item_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  utf8sd_pkg::out_item_t out_data,
  output int                    mismatch_count,
  output int                    chars_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  utf8sd_pkg::out_item_t          chars_due[$];
  utf8sd_pkg::out_item_t          word_res[2];
  int                             word_n;
  logic [utf8sd_pkg::ACC_W-1:0]   acc_bits;
  logic [utf8sd_pkg::PEND_W-1:0]  cont_left;
  int                             errs = 0;

  function automatic utf8sd_pkg::out_item_t char_result(
      input logic [utf8sd_pkg::CP_W-1:0] cp, input logic [1:0] st);
    utf8sd_pkg::out_item_t r;
    r.code_point = (st == utf8sd_pkg::ST_OK) ? cp : '0;
    r.status     = st;
    r.run_last   = 1'b0;
    return r;
  endfunction

  task automatic add_char(input logic [utf8sd_pkg::CP_W-1:0] cp, input logic [1:0] st);
    if (word_n < 2) begin
      word_res[word_n] = char_result(cp, st);
      word_n++;
    end
  endtask

  // a lead byte either gives a result at once or opens a sequence
  task automatic start_char(input logic [7:0] b);
    if (b < 8'h80) begin
      add_char({13'd0, b}, utf8sd_pkg::ST_OK);
    end else if (b < 8'hC0 || b >= 8'hFE) begin
      add_char('0, utf8sd_pkg::ST_BAD_LEAD);
    end else if (b < 8'hE0) begin
      acc_bits  = {23'd0, b & 8'h1F};
      cont_left = 3'd1;
    end else if (b < 8'hF0) begin
      acc_bits  = {23'd0, b & 8'h0F};
      cont_left = 3'd2;
    end else if (b < 8'hF8) begin
      acc_bits  = {23'd0, b & 8'h07};
      cont_left = 3'd3;
    end else if (b < 8'hFC) begin
      acc_bits  = {23'd0, b & 8'h03};
      cont_left = 3'd4;
    end else begin
      acc_bits  = {23'd0, b & 8'h01};
      cont_left = 3'd5;
    end
  endtask

  task automatic decode_byte(input utf8sd_pkg::in_item_t w);
    logic [utf8sd_pkg::ACC_W-1:0] v;
    word_n = 0;
    if (cont_left != 0) begin
      if (w.data_byte[7:6] == 2'b10) begin
        acc_bits  = {acc_bits[utf8sd_pkg::ACC_W-7:0], w.data_byte[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 0) begin
          v = acc_bits;
          if ((v >= 31'h00D800 && v <= 31'h00DFFF) || v == 31'h00FFFE ||
              v == 31'h00FFFF || v > 31'h10FFFF) begin
            add_char('0, utf8sd_pkg::ST_DISALLOWED);
          end else begin
            add_char(v[utf8sd_pkg::CP_W-1:0], utf8sd_pkg::ST_OK);
          end
          acc_bits = '0;
        end
      end else begin
        // not a continuation: close the open sequence, then treat as a new lead
        add_char('0, utf8sd_pkg::ST_BROKEN);
        acc_bits  = '0;
        cont_left = '0;
        start_char(w.data_byte);
      end
    end else begin
      start_char(w.data_byte);
    end
    if (w.is_last && cont_left != 0) begin
      add_char('0, utf8sd_pkg::ST_BROKEN);
      acc_bits  = '0;
      cont_left = '0;
    end
    if (word_n > 0) begin
      word_res[word_n-1].run_last = 1'b1;
    end
    for (int k = 0; k < word_n; k++) begin
      chars_due.push_back(word_res[k]);
    end
  endtask

  always @(posedge clk) begin
    utf8sd_pkg::out_item_t want;
    if (!rst_n) begin
      acc_bits  = '0;
      cont_left = '0;
      chars_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
      end
      if (out_valid && !out_stall) begin
        if (chars_due.size() == 0) begin
          if (errs < 10) begin
            $display("unexpected result: cp=%h status=%0d run_last=%0b",
                     out_data.code_point, out_data.status, out_data.run_last);
          end
          errs++;
        end else begin
          want = chars_due.pop_front();
          if (out_data.code_point !== want.code_point || out_data.status !== want.status ||
              out_data.run_last !== want.run_last) begin
            if (errs < 10) begin
              $display("mismatch: expected cp=%h status=%0d run_last=%0b,",
                       want.code_point, want.status, want.run_last,
                       " got cp=%h status=%0d run_last=%0b",
                       out_data.code_point, out_data.status, out_data.run_last);
            end
            errs++;
          end
        end
      end
    end
    chars_owed     <= chars_due.size();
    mismatch_count <= errs;
  end

endmodule

>>> verif/tb_top.sv
// testbench top for the utf-8 stream decoder: clock, reset, byte stimulus and verdict
// depends on utf8sd_pkg, utf8_stream_decoder_top and utf8sd_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  utf8sd_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  utf8sd_pkg::out_item_t out_data;
  int        mismatch_count;
  int        chars_owed;
  logic      hold_req;
  int        cycle_cnt = 0;
  int        burst_left = 0;
  int        bytes_sent = 0;
  logic [7:0] str_q[$];

  utf8_stream_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  utf8sd_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .chars_owed     (chars_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic tail);
    int gap;
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(99);
      gap  = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, tail};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_string();
    foreach (str_q[k]) begin
      send_byte(str_q[k], k == str_q.size() - 1);
    end
    str_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (chars_owed != 0);
  endtask

  function automatic int rand_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return 1;
    if (pick < 50) return 2;
    if (pick < 68) return 3;
    if (pick < 84) return 4;
    if (pick < 92) return 5;
    return 6;
  endfunction

  // any value that an n-byte form can carry, overlong ones included
  function automatic logic [30:0] rand_payload(input int n);
    logic [30:0] m;
    m = '1;
    if (n == 1) return 31'($urandom_range(0, 127));
    m = m >> (31 - (5 * n + 1));
    return 31'($urandom) & m;
  endfunction

  // encode v in n bytes and queue the first keep of them
  task automatic push_char(input logic [30:0] v, input int n, input int keep);
    logic [7:0] enc[6];
    if (n == 1) begin
      enc[0] = {1'b0, v[6:0]};
    end else begin
      enc[0] = 8'(8'hFF << (8 - n)) | 8'(v >> (6 * (n - 1)));
      for (int k = 1; k < n; k++) begin
        enc[k] = {2'b10, 6'(v >> (6 * (n - 1 - k)))};
      end
    end
    for (int k = 0; k < keep; k++) begin
      str_q.push_back(enc[k]);
    end
  endtask

  task automatic push_partial();
    int n;
    n = $urandom_range(2, 6);
    push_char(rand_payload(n), n, $urandom_range(1, n - 1));
  endtask

  // result side: random stalls plus one long hold-off once requested
  initial begin
    int  stall_len;
    int  pick;
    bit  hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_len = HOLD_CYCLES;
      end else begin
        pick      = $urandom_range(99);
        stall_len = (pick < 55) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [30:0] v;
    int          n;
    int          pick;
    bit          paused;
    paused   = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    hold_req <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ascii floor, bad leads, top byte value
    str_q = '{8'h00, 8'h80, 8'hFE, 8'hFF};
    send_string();
    // overlong two-byte zero, surrogate, value above the unicode range
    str_q = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80};
    send_string();
    // legacy five and six byte forms
    str_q = '{8'hF8, 8'h80, 8'h80, 8'h80, 8'h81, 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
    send_string();
    // two broken sequences, then a lead that is cut off by the end of the string
    str_q = '{8'hC3, 8'h41, 8'hE2, 8'hF0};
    send_string();
    wait_drained();

    hold_req   <= 1'b1;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (!paused && bytes_sent >= RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        burst_left = $urandom_range(40, 80);
      end
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          n = rand_len();
          push_char(rand_payload(n), n, n);
        end else if (pick < 72) begin
          case ($urandom_range(0, 7))
            0:       v = 31'h00D800;
            1:       v = 31'h00DFFF;
            2:       v = 31'h00FFFE;
            3:       v = 31'h00FFFF;
            4:       v = 31'h10FFFF;
            5:       v = 31'h110000;
            6:       v = 31'h00D7FF;
            default: v = 31'h00E000;
          endcase
          n = ((v < 31'h010000) ? 3 : 4) + $urandom_range(0, 2);
          if (n > 6) n = 6;
          push_char(v, n, n);
        end else if (pick < 86) begin
          push_partial();
        end else begin
          str_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      // some strings end inside a sequence
      if ($urandom_range(4) == 0) begin
        push_partial();
      end
      send_string();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/utf8sd_pkg.sv
design/utf8sd_decode.sv
design/utf8sd_rqueue.sv
design/utf8_stream_decoder_top.sv
verif/utf8sd_checker.sv
verif/tb_top.sv
